// ----- hdl/prep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_pkg
// Shared types and constants of the probe request element parser.
// ----------------------------------------------------------------------------
package prep_pkg;

  // Parser mode
  typedef enum logic [2:0] {
    MODE_IGNORE = 3'd0,
    MODE_ID     = 3'd1,
    MODE_LEN    = 3'd2,
    MODE_VALUE  = 3'd3,
    MODE_STOP   = 3'd4
  } mode_e;

  // Class of the element being walked
  typedef enum logic [2:0] {
    KIND_SSID   = 3'd0,
    KIND_RATES  = 3'd1,
    KIND_DSSS   = 3'd2,
    KIND_HT     = 3'd3,
    KIND_COEX   = 3'd4,
    KIND_EXTCAP = 3'd5,
    KIND_SKIP   = 3'd6
  } kind_e;

  // Element ids
  localparam logic [7:0] ID_SSID   = 8'd0;
  localparam logic [7:0] ID_RATES  = 8'd1;
  localparam logic [7:0] ID_DSSS   = 8'd3;
  localparam logic [7:0] ID_HT     = 8'd45;
  localparam logic [7:0] ID_COEX   = 8'd72;
  localparam logic [7:0] ID_EXTCAP = 8'd127;
  localparam logic [7:0] ID_VENDOR = 8'd221;

  // Frame control filter
  localparam logic [15:0] FC_TYPE_MASK = 16'hFF00;
  localparam logic [15:0] FC_PROBE_REQ = 16'h4000;
  localparam logic [15:0] FC_ORDER_BIT = 16'h0001;

  // Field codes of element records
  localparam logic [3:0] FC_SSID     = 4'd0;
  localparam logic [3:0] FC_RATES    = 4'd1;
  localparam logic [3:0] FC_DSSS     = 4'd2;
  localparam logic [3:0] FC_HTCAP    = 4'd3;
  localparam logic [3:0] FC_AMPDU    = 4'd4;
  localparam logic [3:0] FC_MCS      = 4'd5;
  localparam logic [3:0] FC_HTEXT    = 4'd6;
  localparam logic [3:0] FC_BEAMFORM = 4'd7;
  localparam logic [3:0] FC_ASEL     = 4'd8;
  localparam logic [3:0] FC_COEX     = 4'd9;
  localparam logic [3:0] FC_EXTCAP   = 4'd10;

  // HT capability value offsets where each sub-field starts
  localparam logic [7:0] HT_AMPDU_OFF = 8'd2;
  localparam logic [7:0] HT_MCS_OFF   = 8'd3;
  localparam logic [7:0] HT_EXT_OFF   = 8'd19;
  localparam logic [7:0] HT_BF_OFF    = 8'd21;
  localparam logic [7:0] HT_ASEL_OFF  = 8'd25;

  // Count saturation limits
  localparam logic [5:0] SSID_CNT_MAX = 6'd63;
  localparam logic [5:0] NIB_CNT_MAX  = 6'd15;

  // Record kinds
  localparam logic REC_ELEMENT   = 1'b0;
  localparam logic REC_FRAME_END = 1'b1;

  // Output queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One result record
  typedef struct packed {
    logic       record_kind;
    logic [3:0] field_code;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic       accepted;
    logic       order_flag;
    logic [5:0] ssid_count;
    logic [3:0] rates_count;
    logic [3:0] ext_cap_count;
    logic       truncated;
    logic       last_of_run;
  } rec_t;

  // Records produced by one request, oldest in rec0
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic kind_e kind_of_id(input logic [7:0] id);
    kind_e k;
    unique case (id)
      ID_SSID:   k = KIND_SSID;
      ID_RATES:  k = KIND_RATES;
      ID_DSSS:   k = KIND_DSSS;
      ID_HT:     k = KIND_HT;
      ID_COEX:   k = KIND_COEX;
      ID_EXTCAP: k = KIND_EXTCAP;
      default:   k = KIND_SKIP;
    endcase
    return k;
  endfunction

  // Raise a count to offset + 1, saturating at maxv, never lowering it
  function automatic logic [5:0] raise_count(input logic [5:0] cnt,
                                             input logic [7:0] off,
                                             input logic [5:0] maxv);
    logic [8:0] n;
    n = {1'b0, off} + 9'd1;
    if (n > {3'b000, maxv}) n = {3'b000, maxv};
    return (n > {3'b000, cnt}) ? n[5:0] : cnt;
  endfunction

endpackage

// ----- hdl/prep_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_parser
// Element walker: holds the per-frame state and turns each accepted request
// into zero, one or two result records.
// ----------------------------------------------------------------------------
module prep_parser
  import prep_pkg::*;
#(
  parameter int unsigned SSID_BYTES    = 32,
  parameter int unsigned RATE_BYTES    = 8,
  parameter int unsigned EXT_CAP_BYTES = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic        action_i,
  input  logic [15:0] frame_control_i,
  input  logic        mgmt_frame_i,
  input  logic [7:0]  body_byte_i,
  input  logic        last_byte_i,
  output push_t       push_o
);

  localparam logic [7:0] SSID_LIM   = 8'(SSID_BYTES);
  localparam logic [7:0] RATE_LIM   = 8'(RATE_BYTES);
  localparam logic [7:0] EXTCAP_LIM = 8'(EXT_CAP_BYTES);

  mode_e      mode_q, mode_d, mode_upd;
  kind_e      kind_q, kind_d;
  logic [7:0] off_q, off_d;
  logic [7:0] rem_q, rem_d, rem_dec;
  logic [5:0] ssid_q, ssid_d, ssid_upd;
  logic [3:0] rates_q, rates_d, rates_upd;
  logic [3:0] ext_q, ext_d, ext_upd;
  logic       acc_flag_q, acc_flag_d;
  logic       order_q, order_d;

  logic       cap;
  logic [3:0] cap_code;
  logic [4:0] cap_index;
  logic [7:0] ht_sub;
  logic       emit_elem;
  logic       trunc;
  rec_t       elem_rec, end_rec;

  // Capture decision for the current value byte
  always_comb begin
    cap       = 1'b0;
    cap_code  = FC_SSID;
    cap_index = 5'd0;
    ht_sub    = 8'd0;
    unique case (kind_q)
      KIND_SSID: begin
        cap       = off_q < SSID_LIM;
        cap_code  = FC_SSID;
        cap_index = off_q[4:0];
      end
      KIND_RATES: begin
        cap       = off_q < RATE_LIM;
        cap_code  = FC_RATES;
        cap_index = off_q[4:0];
      end
      KIND_DSSS: begin
        cap      = off_q == 8'd0;
        cap_code = FC_DSSS;
      end
      KIND_COEX: begin
        cap      = off_q == 8'd0;
        cap_code = FC_COEX;
      end
      KIND_EXTCAP: begin
        cap       = off_q < EXTCAP_LIM;
        cap_code  = FC_EXTCAP;
        cap_index = off_q[4:0];
      end
      KIND_HT: begin
        cap = 1'b1;
        priority if (off_q < HT_AMPDU_OFF) begin
          cap_code = FC_HTCAP;
          ht_sub   = off_q;
        end else if (off_q == HT_AMPDU_OFF) begin
          cap_code = FC_AMPDU;
        end else if (off_q < HT_EXT_OFF) begin
          cap_code = FC_MCS;
          ht_sub   = off_q - HT_MCS_OFF;
        end else if (off_q < HT_BF_OFF) begin
          cap_code = FC_HTEXT;
          ht_sub   = off_q - HT_EXT_OFF;
        end else if (off_q < HT_ASEL_OFF) begin
          cap_code = FC_BEAMFORM;
          ht_sub   = off_q - HT_BF_OFF;
        end else if (off_q == HT_ASEL_OFF) begin
          cap_code = FC_ASEL;
        end else begin
          cap = 1'b0;
        end
        cap_index = ht_sub[4:0];
      end
      default: cap = 1'b0;
    endcase
  end

  // Next state and records
  always_comb begin
    mode_d     = mode_q;
    kind_d     = kind_q;
    off_d      = off_q;
    rem_d      = rem_q;
    ssid_d     = ssid_q;
    rates_d    = rates_q;
    ext_d      = ext_q;
    acc_flag_d = acc_flag_q;
    order_d    = order_q;
    mode_upd   = mode_q;
    ssid_upd   = ssid_q;
    rates_upd  = rates_q;
    ext_upd    = ext_q;
    rem_dec    = rem_q - 8'd1;
    emit_elem  = 1'b0;
    trunc      = 1'b0;
    elem_rec   = '0;
    end_rec    = '0;
    push_o     = '0;

    if (acc_i && !action_i) begin
      // Header request restarts the frame
      acc_flag_d = mgmt_frame_i && ((frame_control_i & FC_TYPE_MASK) == FC_PROBE_REQ);
      order_d    = (frame_control_i & FC_ORDER_BIT) != 16'd0;
      ssid_d     = 6'd0;
      rates_d    = 4'd0;
      ext_d      = 4'd0;
      kind_d     = KIND_SSID;
      off_d      = 8'd0;
      rem_d      = 8'd0;
      mode_d     = acc_flag_d ? MODE_ID : MODE_IGNORE;
    end else if (acc_i) begin
      // Body byte
      unique case (mode_q)
        MODE_ID: begin
          if (body_byte_i == ID_VENDOR) begin
            mode_upd = MODE_STOP;
          end else begin
            kind_d   = kind_of_id(body_byte_i);
            mode_upd = MODE_LEN;
          end
        end
        MODE_LEN: begin
          rem_d    = body_byte_i;
          off_d    = 8'd0;
          mode_upd = (body_byte_i != 8'd0) ? MODE_VALUE : MODE_ID;
        end
        MODE_VALUE: begin
          emit_elem = cap;
          if (cap && kind_q == KIND_SSID)
            ssid_upd = raise_count(ssid_q, off_q, SSID_CNT_MAX);
          if (cap && kind_q == KIND_RATES)
            rates_upd = 4'(raise_count({2'b00, rates_q}, off_q, NIB_CNT_MAX));
          if (cap && kind_q == KIND_EXTCAP)
            ext_upd = 4'(raise_count({2'b00, ext_q}, off_q, NIB_CNT_MAX));
          off_d = off_q + 8'd1;
          rem_d = rem_dec;
          if (rem_dec == 8'd0) mode_upd = MODE_ID;
        end
        default: ;
      endcase
      mode_d  = mode_upd;
      ssid_d  = ssid_upd;
      rates_d = rates_upd;
      ext_d   = ext_upd;

      elem_rec.record_kind   = REC_ELEMENT;
      elem_rec.field_code    = cap_code;
      elem_rec.byte_index    = cap_index;
      elem_rec.byte_value    = body_byte_i;
      elem_rec.accepted      = acc_flag_q;
      elem_rec.order_flag    = order_q;
      elem_rec.ssid_count    = ssid_upd;
      elem_rec.rates_count   = rates_upd;
      elem_rec.ext_cap_count = ext_upd;
      elem_rec.truncated     = 1'b0;
      elem_rec.last_of_run   = !last_byte_i;

      trunc = (mode_upd == MODE_LEN) || (mode_upd == MODE_VALUE);
      end_rec.record_kind   = REC_FRAME_END;
      end_rec.accepted      = acc_flag_q;
      end_rec.order_flag    = order_q;
      end_rec.ssid_count    = ssid_upd;
      end_rec.rates_count   = rates_upd;
      end_rec.ext_cap_count = ext_upd;
      end_rec.truncated     = trunc;
      end_rec.last_of_run   = 1'b1;

      // Records, oldest first
      unique case ({emit_elem, last_byte_i})
        2'b11: begin
          push_o.count = 2'd2;
          push_o.rec0  = elem_rec;
          push_o.rec1  = end_rec;
        end
        2'b10: begin
          push_o.count = 2'd1;
          push_o.rec0  = elem_rec;
        end
        2'b01: begin
          push_o.count = 2'd1;
          push_o.rec0  = end_rec;
        end
        default: push_o.count = 2'd0;
      endcase

      // Frame end clears everything
      if (last_byte_i) begin
        mode_d     = MODE_IGNORE;
        kind_d     = KIND_SSID;
        off_d      = 8'd0;
        rem_d      = 8'd0;
        ssid_d     = 6'd0;
        rates_d    = 4'd0;
        ext_d      = 4'd0;
        acc_flag_d = 1'b0;
        order_d    = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IGNORE;
      kind_q     <= KIND_SSID;
      off_q      <= 8'd0;
      rem_q      <= 8'd0;
      ssid_q     <= 6'd0;
      rates_q    <= 4'd0;
      ext_q      <= 4'd0;
      acc_flag_q <= 1'b0;
      order_q    <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      kind_q     <= kind_d;
      off_q      <= off_d;
      rem_q      <= rem_d;
      ssid_q     <= ssid_d;
      rates_q    <= rates_d;
      ext_q      <= ext_d;
      acc_flag_q <= acc_flag_d;
      order_q    <= order_d;
    end
  end

  // Header requests never produce records
  a_header_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !action_i) |-> (push_o.count == 2'd0))
    else $error("header request produced a record");

  // A pair is always an element record followed by the frame end record
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |->
      (push_o.rec0.record_kind == REC_ELEMENT && push_o.rec1.record_kind == REC_FRAME_END))
    else $error("record pair out of order");

  // The final body byte leaves the parser idle with counts cleared
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && action_i && last_byte_i) |=>
      (mode_q == MODE_IGNORE && ssid_q == 6'd0 && !acc_flag_q))
    else $error("frame end did not clear parser state");

endmodule

// ----- hdl/prep_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_out_queue
// Small result queue: up to two records in a cycle, one out while ready.
// ----------------------------------------------------------------------------
module prep_out_queue
  import prep_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output rec_t  head_o
);

  rec_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, wr_next;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_q];
  // Room for a full pair of records
  assign room_o  = cnt_q <= QCNT_W'(QDEPTH - 2);
  assign wr_next = wr_q + QPTR_W'(1);

  always_comb begin
    wr_d  = wr_q + QPTR_W'(push_i.count);
    rd_d  = pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i.count) - QCNT_W'(pop);
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.rec0;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.rec1;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (cnt_q <= QCNT_W'(QDEPTH - 2)))
    else $error("records pushed without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != QCNT_W'(QDEPTH)) |-> (QPTR_W'(wr_q - rd_q) == cnt_q[QPTR_W-1:0]))
    else $error("queue pointers disagree with fill count");

endmodule

// ----- hdl/probe_request_element_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_request_element_parser
// Filters probe request frames and emits their known element bytes, tagged
// by field and index, plus a frame end record with counts and flags.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request per header item (tuser = 0) and then one per
//   body byte (tuser = 1), tlast on the final body byte of the frame.
//   Master stream: result records, tuser = record kind (0 element byte,
//   1 frame end), tlast on the final record caused by one request.
//   Order: each record enters the result queue when the request that causes
//   it is accepted, and records leave on the master side in that order.
//   Throughput: one request per cycle while the queue has room. A request
//   yields zero, one or two records; the master side delivers one record per
//   cycle while tready is high, so the rate is set by the four-entry result
//   queue, which takes a request only while at least two entries are free.
//   Stall: when the receiver holds tready low the queue fills and the slave
//   tready drops; nothing is lost or repeated.
//   Reset: parser idles ignoring body bytes until a header arrives; the
//   queue is emptied. No clearing pass is needed.
// ----------------------------------------------------------------------------
module probe_request_element_parser
  import prep_pkg::*;
#(
  parameter int unsigned SSID_BYTES    = 32,
  parameter int unsigned RATE_BYTES    = 8,
  parameter int unsigned EXT_CAP_BYTES = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] frame_control, [16] mgmt_frame, [24:17] body_byte, [31:25] zero
  input  logic [31:0] s_axis_tdata_i,
  // [0] action
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] field_code, [8:4] byte_index, [16:9] byte_value, [17] accepted,
  // [18] order_flag, [24:19] ssid_count, [28:25] rates_count,
  // [32:29] ext_cap_count, [33] truncated, [39:34] zero
  output logic [39:0] m_axis_tdata_o,
  // [0] record_kind
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic  room;
  logic  acc;
  push_t push;
  rec_t  head;

  assign s_axis_tready_o = room;
  assign acc             = s_axis_tvalid_i && room;

  prep_parser #(
    .SSID_BYTES   (SSID_BYTES),
    .RATE_BYTES   (RATE_BYTES),
    .EXT_CAP_BYTES(EXT_CAP_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .action_i       (s_axis_tuser_i[0]),
    .frame_control_i(s_axis_tdata_i[15:0]),
    .mgmt_frame_i   (s_axis_tdata_i[16]),
    .body_byte_i    (s_axis_tdata_i[24:17]),
    .last_byte_i    (s_axis_tlast_i),
    .push_o         (push)
  );

  prep_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .head_o (head)
  );

  // Pack the head record onto the master stream
  assign m_axis_tdata_o = {6'd0,
                           head.truncated,
                           head.ext_cap_count,
                           head.rates_count,
                           head.ssid_count,
                           head.order_flag,
                           head.accepted,
                           head.byte_value,
                           head.byte_index,
                           head.field_code};
  assign m_axis_tuser_o = head.record_kind;
  assign m_axis_tlast_o = head.last_of_run;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the probe request element parser. The bench
// streams frame headers and body bytes into the slave side and tracks the
// element walk in its own prediction. Every record on the master side is
// compared field by field against the oldest predicted record. The
// stimulus is a directed set of element cases followed by randomized
// probe requests, broken frames and noise, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import prep_pkg::*;

  localparam int unsigned SSID_MAX   = 32;
  localparam int unsigned RATES_MAX  = 8;
  localparam int unsigned EXTCAP_MAX = 11;

  // Request kinds carried on tuser
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_BODY   = 1'b1;

  // An element id that the parser walks over by its length
  localparam logic [7:0] ID_EXT_RATES = 8'd50;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic [0:0]  s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Parser state as predicted
  mode_e       pmode      = MODE_IGNORE;
  kind_e       ekind      = KIND_SSID;
  logic [7:0]  eoff       = '0;
  logic [7:0]  erem       = '0;
  logic [5:0]  ssid_len   = '0;
  logic [3:0]  rate_len   = '0;
  logic [3:0]  extcap_len = '0;
  logic        frame_ok   = 1'b0;
  logic        order_bit  = 1'b0;

  rec_t        expected_recs[$];
  logic [7:0]  body_q[$];

  int unsigned mismatch_count  = 0;
  int unsigned records_checked = 0;
  int unsigned items_parsed    = 0;
  int unsigned frame_ends      = 0;
  int unsigned accepted_ends   = 0;
  int unsigned truncated_ends  = 0;
  bit          quiet           = 1'b0;

  probe_request_element_parser #(
    .SSID_BYTES   (SSID_MAX),
    .RATE_BYTES   (RATES_MAX),
    .EXT_CAP_BYTES(EXTCAP_MAX)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Walk one accepted request and queue the records it should produce
  function automatic void predict_request(input logic action, input logic [15:0] fc,
                                          input logic mgmt, input logic [7:0] b,
                                          input logic last);
    rec_t       elem;
    rec_t       fin;
    logic       have_elem;
    logic [3:0] code;
    logic [4:0] idx;
    logic [7:0] rel;
    elem      = '0;
    fin       = '0;
    have_elem = 1'b0;
    code      = '0;
    idx       = '0;
    rel       = '0;

    // Header: filter and restart the frame
    if (action == ACT_HEADER) begin
      frame_ok   = mgmt && ((fc & FC_TYPE_MASK) == FC_PROBE_REQ);
      order_bit  = (fc & FC_ORDER_BIT) != 16'd0;
      ssid_len   = '0;
      rate_len   = '0;
      extcap_len = '0;
      ekind      = KIND_SSID;
      eoff       = '0;
      erem       = '0;
      pmode      = frame_ok ? MODE_ID : MODE_IGNORE;
      items_parsed++;
      return;
    end

    if (pmode inside {MODE_ID, MODE_LEN, MODE_VALUE} || last) items_parsed++;

    case (pmode)
      MODE_ID: begin
        if (b == ID_VENDOR) begin
          pmode = MODE_STOP;
        end else begin
          case (b)
            ID_SSID:   ekind = KIND_SSID;
            ID_RATES:  ekind = KIND_RATES;
            ID_DSSS:   ekind = KIND_DSSS;
            ID_HT:     ekind = KIND_HT;
            ID_COEX:   ekind = KIND_COEX;
            ID_EXTCAP: ekind = KIND_EXTCAP;
            default:   ekind = KIND_SKIP;
          endcase
          pmode = MODE_LEN;
        end
      end
      MODE_LEN: begin
        erem  = b;
        eoff  = '0;
        pmode = (b != 8'd0) ? MODE_VALUE : MODE_ID;
      end
      MODE_VALUE: begin
        have_elem = 1'b1;
        case (ekind)
          KIND_SSID: begin
            if (eoff < SSID_MAX) begin
              code = FC_SSID;
              idx  = eoff[4:0];
              if (eoff + 1 > ssid_len) ssid_len = 6'(eoff + 8'd1);
            end else begin
              have_elem = 1'b0;
            end
          end
          KIND_RATES: begin
            if (eoff < RATES_MAX) begin
              code = FC_RATES;
              idx  = eoff[4:0];
              if (eoff + 1 > rate_len) rate_len = 4'(eoff + 8'd1);
            end else begin
              have_elem = 1'b0;
            end
          end
          KIND_EXTCAP: begin
            if (eoff < EXTCAP_MAX) begin
              code = FC_EXTCAP;
              idx  = eoff[4:0];
              if (eoff + 1 > extcap_len) extcap_len = 4'(eoff + 8'd1);
            end else begin
              have_elem = 1'b0;
            end
          end
          KIND_DSSS: begin
            code      = FC_DSSS;
            have_elem = (eoff == 8'd0);
          end
          KIND_COEX: begin
            code      = FC_COEX;
            have_elem = (eoff == 8'd0);
          end
          KIND_HT: begin
            // HT capability layout split into its sub-fields
            if (eoff < HT_AMPDU_OFF) begin
              code = FC_HTCAP;
              rel  = eoff;
            end else if (eoff == HT_AMPDU_OFF) begin
              code = FC_AMPDU;
            end else if (eoff < HT_EXT_OFF) begin
              code = FC_MCS;
              rel  = eoff - HT_MCS_OFF;
            end else if (eoff < HT_BF_OFF) begin
              code = FC_HTEXT;
              rel  = eoff - HT_EXT_OFF;
            end else if (eoff < HT_ASEL_OFF) begin
              code = FC_BEAMFORM;
              rel  = eoff - HT_BF_OFF;
            end else if (eoff == HT_ASEL_OFF) begin
              code = FC_ASEL;
            end else begin
              have_elem = 1'b0;
            end
            idx = rel[4:0];
          end
          default: have_elem = 1'b0;
        endcase
        if (have_elem) begin
          elem.record_kind   = REC_ELEMENT;
          elem.field_code    = code;
          elem.byte_index    = idx;
          elem.byte_value    = b;
          elem.accepted      = frame_ok;
          elem.order_flag    = order_bit;
          elem.ssid_count    = ssid_len;
          elem.rates_count   = rate_len;
          elem.ext_cap_count = extcap_len;
        end
        eoff = eoff + 8'd1;
        erem = erem - 8'd1;
        if (erem == 8'd0) pmode = MODE_ID;
      end
      default: ;
    endcase

    // Final body byte: frame end record, then back to ignoring
    if (last) begin
      fin.record_kind   = REC_FRAME_END;
      fin.accepted      = frame_ok;
      fin.order_flag    = order_bit;
      fin.ssid_count    = ssid_len;
      fin.rates_count   = rate_len;
      fin.ext_cap_count = extcap_len;
      fin.truncated     = (pmode == MODE_LEN) || (pmode == MODE_VALUE);
      fin.last_of_run   = 1'b1;
      frame_ends++;
      if (frame_ok) accepted_ends++;
      if (fin.truncated) truncated_ends++;
      pmode      = MODE_IGNORE;
      ekind      = KIND_SSID;
      eoff       = '0;
      erem       = '0;
      ssid_len   = '0;
      rate_len   = '0;
      extcap_len = '0;
      frame_ok   = 1'b0;
      order_bit  = 1'b0;
    end else if (have_elem) begin
      elem.last_of_run = 1'b1;
    end
    if (have_elem) expected_recs.push_back(elem);
    if (last) expected_recs.push_back(fin);
  endfunction

  // Slave side: predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      predict_request(s_axis_tuser_i[0], s_axis_tdata_i[15:0], s_axis_tdata_i[16],
                      s_axis_tdata_i[24:17], s_axis_tlast_i);
  end

  // Master side: compare each record with the oldest prediction
  always @(posedge clk_i) begin
    rec_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_recs.size() == 0) begin
        report_mismatch("record with none pending", m_axis_tuser_o[0], 0);
      end else begin
        want = expected_recs.pop_front();
        records_checked++;
        check_field("record_kind", m_axis_tuser_o[0], want.record_kind);
        check_field("field_code", m_axis_tdata_o[3:0], want.field_code);
        check_field("byte_index", m_axis_tdata_o[8:4], want.byte_index);
        check_field("byte_value", m_axis_tdata_o[16:9], want.byte_value);
        check_field("accepted", m_axis_tdata_o[17], want.accepted);
        check_field("order_flag", m_axis_tdata_o[18], want.order_flag);
        check_field("ssid_count", m_axis_tdata_o[24:19], want.ssid_count);
        check_field("rates_count", m_axis_tdata_o[28:25], want.rates_count);
        check_field("ext_cap_count", m_axis_tdata_o[32:29], want.ext_cap_count);
        check_field("truncated", m_axis_tdata_o[33], want.truncated);
        check_field("last_of_run", m_axis_tlast_o, want.last_of_run);
      end
    end
  end

  // Receiver: random stalls between bursts of ready
  initial begin
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Send one request; valid stays high afterwards unless the next one idles
  task automatic send_request(input logic action, input logic [15:0] fc, input logic mgmt,
                              input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= action;
    s_axis_tlast_i  <= last;
    s_axis_tdata_i  <= {7'd0, b, mgmt, fc};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Fields that a request kind ignores get random values
  task automatic send_header(input logic [15:0] fc, input logic mgmt);
    send_request(ACT_HEADER, fc, mgmt, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_body(input logic [7:0] b, input logic last);
    send_request(ACT_BODY, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), b, last);
  endtask

  task automatic send_body_q();
    for (int i = 0; i < body_q.size(); i++) send_body(body_q[i], i == body_q.size() - 1);
    body_q.delete();
  endtask

  task automatic add_element(input logic [7:0] id, input int unsigned len);
    body_q.push_back(id);
    body_q.push_back(len[7:0]);
    repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_element_id();
    case ($urandom_range(0, 9))
      0, 1:    return ID_SSID;
      2:       return ID_RATES;
      3:       return ID_DSSS;
      4, 5:    return ID_HT;
      6:       return ID_COEX;
      7:       return ID_EXTCAP;
      8:       return ID_EXT_RATES;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_length(input logic [7:0] id);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r == 0) return $urandom_range(0, 255);
    case (id)
      ID_SSID:          return (r < 80) ? $urandom_range(0, SSID_MAX) : $urandom_range(33, 40);
      ID_RATES:         return $urandom_range(0, 12);
      ID_HT:            return (r < 70) ? HT_ASEL_OFF + 1 : $urandom_range(0, 30);
      ID_EXTCAP:        return $urandom_range(0, 16);
      ID_DSSS, ID_COEX: return (r < 70) ? 1 : $urandom_range(0, 3);
      default:          return $urandom_range(0, 10);
    endcase
  endfunction

  // Stop sending and wait until every predicted record has come out
  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_recs.size() != 0) @(posedge clk_i);
  endtask

  // One random frame: mostly well-formed probe requests, some noise
  task automatic run_random_frame();
    int unsigned r;
    int unsigned keep;
    logic [7:0]  id;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send_header(FC_PROBE_REQ | 16'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(0, 6)) begin
        id = pick_element_id();
        add_element(id, pick_length(id));
      end
      if ($urandom_range(0, 9) == 0) add_element(ID_VENDOR, $urandom_range(0, 6));
      if ($urandom_range(0, 7) == 0 && body_q.size() > 1) begin
        keep = $urandom_range(1, body_q.size() - 1);
        while (body_q.size() > keep) void'(body_q.pop_back());
      end
      if (body_q.size() == 0) body_q.push_back(8'($urandom_range(0, 255)));
      send_body_q();
    end else if (r < 88) begin
      // accepted header, garbage body
      send_header(FC_PROBE_REQ | 16'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
      send_body_q();
    end else if (r < 95) begin
      // arbitrary header, usually rejected
      send_header(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(0, 255)));
      send_body_q();
    end else begin
      // frame abandoned before its last byte
      send_header(FC_PROBE_REQ | 16'($urandom_range(0, 255)), 1'b1);
      id = pick_element_id();
      add_element(id, pick_length(id));
      for (int i = 0; i < body_q.size(); i++) send_body(body_q[i], 1'b0);
      body_q.delete();
    end
    // stray bytes between frames
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_body(8'($urandom_range(0, 255)), 1'b0);
    if ($urandom_range(0, 19) == 0) send_body(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_stray_last();
    send_body(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_rejected_frame();
    send_header(FC_PROBE_REQ, 1'b0);
    send_body(ID_SSID, 1'b1);
  endtask

  task automatic test_element_mix();
    send_header(FC_PROBE_REQ | 16'h00FF, 1'b1);
    add_element(ID_SSID, 0);
    add_element(ID_COEX, 2);
    add_element(ID_EXT_RATES, 1);
    add_element(ID_EXTCAP, 1);
    // frame ends on a length byte
    body_q.push_back(ID_RATES);
    body_q.push_back(8'd3);
    send_body_q();
  endtask

  task automatic test_vendor_stop();
    send_header(FC_PROBE_REQ, 1'b1);
    send_body(ID_VENDOR, 1'b0);
    send_body(8'hFF, 1'b1);
  endtask

  task automatic test_abandoned_frame();
    send_header(16'hFFFF, 1'b1);
    send_header(FC_PROBE_REQ, 1'b1);
    send_body(ID_SSID, 1'b0);
    send_body(8'd5, 1'b0);
    send_body(8'h00, 1'b0);
    // restart mid element, then a frame ending exactly on a value byte
    send_header(16'h0000, 1'b1);
    send_header(FC_PROBE_REQ, 1'b1);
    add_element(ID_DSSS, 1);
    send_body_q();
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned stop_at;
    stop_at = items_parsed + target;
    while (items_parsed < stop_at) run_random_frame();
  endtask

  task automatic test_sender_pause();
    wait_results_drained();
    test_random_frames(50);
  endtask

  task automatic test_back_to_back(input int unsigned target);
    quiet = 1'b1;
    test_random_frames(target);
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= ACT_HEADER;
    s_axis_tlast_i  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_last();
    test_rejected_frame();
    test_element_mix();
    test_vendor_stop();
    test_abandoned_frame();
    test_random_frames(600);
    test_sender_pause();
    test_back_to_back(200);
    test_random_frames(450);

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (expected_recs.size() != 0)
      report_mismatch("records never delivered", 0, expected_recs.size());

    $display("run: %0d requests parsed, %0d records checked, %0d mismatches",
             items_parsed, records_checked, mismatch_count);
    $display("frames: %0d ends, %0d accepted, %0d truncated",
             frame_ends, accepted_ends, truncated_ends);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
